@@ src/erpd_pkg.sv @@
`default_nettype none

package erpd_pkg;

	localparam int RING_DEPTH = 8;
	localparam int RING_AW    = $clog2(RING_DEPTH);

	localparam int ECHO_W   = 16;
	localparam int DIST_W   = 17;
	localparam int PCT_W    = 8;
	localparam int FLAGS_W  = 5;
	localparam int SUM_W    = DIST_W + RING_AW;
	localparam int CMP_W    = SUM_W + PCT_W + 1;

	// duration * 256 / 148 == floor(duration * DIST_RECIP / 2^DIST_SHIFT) over 16-bit input
	localparam int DIST_RECIP_W        = 23;
	localparam logic [DIST_RECIP_W-1:0] DIST_RECIP = 23'd7255013;
	localparam int DIST_SHIFT          = 22;
	localparam int DIST_PROD_W         = ECHO_W + DIST_RECIP_W;

	localparam int PCT_BASE   = 100;
	localparam int PRES_SCALE = PCT_BASE * RING_DEPTH;

	localparam int NUM_REGS = 6;
	localparam int ADDR_W   = $clog2(NUM_REGS * 4);
	localparam int DATA_W   = 32;

	localparam int FLAG_OBSTACLE = 0;
	localparam int FLAG_PRESENCE = 1;
	localparam int FLAG_STRONG   = 2;
	localparam int FLAG_MODERATE = 3;
	localparam int FLAG_WEAK     = 4;

	typedef logic [DIST_W-1:0]  dist_t;
	typedef logic [SUM_W-1:0]   sum_t;
	typedef logic [RING_AW-1:0] slot_t;
	typedef logic [PCT_W-1:0]   pct_t;
	typedef logic [CMP_W-1:0]   cmp_t;

	typedef enum logic [2:0] {
		REG_ENABLED        = 3'd0,
		REG_OBSTACLE_LIMIT = 3'd1,
		REG_PRESENCE_LIMIT = 3'd2,
		REG_PRESENCE_PCT   = 3'd3,
		REG_STRONG_PCT     = 3'd4,
		REG_WEAK_PCT       = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic  enabled;
		dist_t obstacle_limit;
		dist_t presence_limit;
		pct_t  presence_margin_pct;
		pct_t  strong_change_pct;
		pct_t  weak_change_pct;
	} cfg_t;

	typedef struct packed {
		logic  en;
		logic  stored;
		dist_t latest;
		sum_t  sum;
		sum_t  prev;
	} ring_item_t;

endpackage

`default_nettype wire

@@ src/erpd_in_if.sv @@
`default_nettype none

interface erpd_in_if;
	import erpd_pkg::*;

	logic              valid;
	logic              ready;
	logic [ECHO_W-1:0] echo_duration_us;
	logic              echo_seen;

	modport source (output valid, output echo_duration_us, output echo_seen, input ready);
	modport sink   (input valid, input echo_duration_us, input echo_seen, output ready);

endinterface

`default_nettype wire

@@ src/erpd_out_if.sv @@
`default_nettype none

interface erpd_out_if;
	import erpd_pkg::*;

	logic               valid;
	logic               ready;
	logic               reading_stored;
	logic [FLAGS_W-1:0] breach_flags;
	logic [DIST_W-1:0]  latest_distance;

	modport source (output valid, output reading_stored, output breach_flags,
		output latest_distance, input ready);
	modport sink   (input valid, input reading_stored, input breach_flags,
		input latest_distance, output ready);

endinterface

`default_nettype wire

@@ src/echo_range_presence_detector.sv @@
`default_nettype none

// Echo range and presence detector. Each transfer on the echo channel is one echo
// measurement; each produces exactly one transfer on the result channel, in order.
// A stored echo becomes a distance in 1/256 inch and enters a ring of the last
// RING_DEPTH readings held in a small synchronous RAM, with a running sum kept
// alongside. One echo is taken per clock cycle when the result side keeps up; a
// result passes through the RAM read of the slot being replaced, the sum update,
// the multipliers of the compares and the output register. Ring entries not yet
// written since reset read as zero, so no clearing pass follows reset. Registers
// sit at byte addresses 4*i on the APB port and are to be written only while no
// echo is in flight.
module echo_range_presence_detector (
	input  logic                           clk,
	input  logic                           arst_n,
	erpd_in_if.sink                        echo,
	erpd_out_if.source                     result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [erpd_pkg::ADDR_W-1:0]    paddr,
	input  logic [erpd_pkg::DATA_W-1:0]    pwdata,
	output logic [erpd_pkg::DATA_W-1:0]    prdata,
	output logic                           pready
);
	import erpd_pkg::*;

	cfg_t       cfg_q;
	reg_idx_t   reg_idx;
	logic       cfg_wr;
	logic       item_valid;
	logic       item_ready;
	ring_item_t item;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled             <= 1'b1;
			cfg_q.obstacle_limit      <= '0;
			cfg_q.presence_limit      <= '0;
			cfg_q.presence_margin_pct <= PCT_W'(10);
			cfg_q.strong_change_pct   <= PCT_W'(10);
			cfg_q.weak_change_pct     <= PCT_W'(5);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_ENABLED:        cfg_q.enabled             <= pwdata[0];
				REG_OBSTACLE_LIMIT: cfg_q.obstacle_limit      <= pwdata[DIST_W-1:0];
				REG_PRESENCE_LIMIT: cfg_q.presence_limit      <= pwdata[DIST_W-1:0];
				REG_PRESENCE_PCT:   cfg_q.presence_margin_pct <= pwdata[PCT_W-1:0];
				REG_STRONG_PCT:     cfg_q.strong_change_pct   <= pwdata[PCT_W-1:0];
				REG_WEAK_PCT:       cfg_q.weak_change_pct     <= pwdata[PCT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ENABLED:        prdata = DATA_W'(cfg_q.enabled);
			REG_OBSTACLE_LIMIT: prdata = DATA_W'(cfg_q.obstacle_limit);
			REG_PRESENCE_LIMIT: prdata = DATA_W'(cfg_q.presence_limit);
			REG_PRESENCE_PCT:   prdata = DATA_W'(cfg_q.presence_margin_pct);
			REG_STRONG_PCT:     prdata = DATA_W'(cfg_q.strong_change_pct);
			REG_WEAK_PCT:       prdata = DATA_W'(cfg_q.weak_change_pct);
			default:            prdata = '0;
		endcase
	end

	erpd_ring u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.enabled    (cfg_q.enabled),
		.echo       (echo),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	erpd_eval u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.result     (result)
	);

endmodule

`default_nettype wire

@@ src/erpd_ram.sv @@
`default_nettype none

module erpd_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 17
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ src/erpd_ring.sv @@
`default_nettype none

module erpd_ring (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 enabled,
	erpd_in_if.sink              echo,
	output logic                 item_valid,
	input  logic                 item_ready,
	output erpd_pkg::ring_item_t item
);
	import erpd_pkg::*;

	logic                   ld_s1;
	logic                   ld_s2;
	logic                   accept;
	logic                   done_s1;
	logic                   commit;
	logic [DIST_PROD_W-1:0] dist_prod;
	dist_t                  ram_rdata;
	dist_t                  old_dist;
	sum_t                   sum_new;
	slot_t                  slot_next;

	logic                   v_s1;
	logic                   en_s1;
	logic                   store_s1;
	logic                   old_vld_s1;
	slot_t                  slot_s1;
	dist_t                  dist_s1;

	slot_t                  write_slot_q;
	sum_t                   running_sum_q;
	sum_t                   previous_sum_q;
	dist_t                  latest_q;
	logic [RING_DEPTH-1:0]  ring_vld_q;

	logic                   v_s2;
	ring_item_t             item_s2;

	assign ld_s2      = !v_s2 || item_ready;
	assign ld_s1      = !v_s1 || ld_s2;
	assign echo.ready = ld_s1;
	assign accept     = echo.valid && ld_s1;
	assign done_s1    = v_s1 && ld_s2;
	assign commit     = done_s1 && store_s1;

	assign dist_prod = DIST_PROD_W'(echo.echo_duration_us) * DIST_PROD_W'(DIST_RECIP);
	assign slot_next = (write_slot_q == slot_t'(RING_DEPTH - 1)) ? '0 : write_slot_q + 1'b1;

	// an entry never written since reset counts as zero
	assign old_dist = old_vld_s1 ? ram_rdata : '0;
	assign sum_new  = running_sum_q - sum_t'(old_dist) + sum_t'(dist_s1);

	erpd_ram #(
		.DEPTH (RING_DEPTH),
		.WIDTH (DIST_W)
	) u_ring_ram (
		.clk   (clk),
		.we    (commit),
		.waddr (slot_s1),
		.wdata (dist_s1),
		.re    (accept),
		.raddr (write_slot_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			en_s1          <= 1'b0;
			store_s1       <= 1'b0;
			v_s2           <= 1'b0;
			write_slot_q   <= '0;
			running_sum_q  <= '0;
			previous_sum_q <= '0;
			latest_q       <= '0;
			ring_vld_q     <= '0;
		end else begin
			if (ld_s1) begin
				v_s1 <= accept;
			end
			if (accept) begin
				en_s1    <= enabled;
				store_s1 <= enabled && echo.echo_seen;
				// advance at accept so the next transfer reads a different slot
				if (enabled && echo.echo_seen) begin
					write_slot_q <= slot_next;
				end
			end
			if (ld_s2) begin
				v_s2 <= v_s1;
			end
			if (commit) begin
				previous_sum_q      <= running_sum_q;
				running_sum_q       <= sum_new;
				latest_q            <= dist_s1;
				ring_vld_q[slot_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_s1    <= write_slot_q;
			dist_s1    <= dist_prod[DIST_SHIFT +: DIST_W];
			old_vld_s1 <= ring_vld_q[write_slot_q];
		end
		if (done_s1) begin
			item_s2.en     <= en_s1;
			item_s2.stored <= store_s1;
			item_s2.latest <= store_s1 ? dist_s1 : latest_q;
			item_s2.sum    <= store_s1 ? sum_new : running_sum_q;
			item_s2.prev   <= store_s1 ? running_sum_q : previous_sum_q;
		end
	end

	assign item_valid = v_s2;
	assign item       = item_s2;

endmodule

`default_nettype wire

@@ src/erpd_eval.sv @@
`default_nettype none

module erpd_eval (
	input  logic                 clk,
	input  logic                 arst_n,
	input  erpd_pkg::cfg_t       cfg,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  erpd_pkg::ring_item_t item,
	erpd_out_if.source           result
);
	import erpd_pkg::*;

	logic               ld_s3;
	logic               ld_out;
	logic [PCT_W:0]     margin_sum;
	sum_t               diff;
	logic               presence;
	logic               is_strong;
	logic               is_weak;
	logic [FLAGS_W-1:0] flags;

	logic               v_s3;
	logic               en_s3;
	logic               stored_s3;
	dist_t              latest_s3;
	logic               obstacle_s3;
	logic               sum_zero_s3;
	logic               limit_nz_s3;
	cmp_t               pres_lhs_s3;
	cmp_t               pres_rhs_s3;
	cmp_t               diff100_s3;
	cmp_t               strong_rhs_s3;
	cmp_t               weak_rhs_s3;

	logic               result_valid_q;
	logic               reading_stored_q;
	logic [FLAGS_W-1:0] breach_flags_q;
	dist_t              latest_distance_q;

	assign ld_out     = !result_valid_q || result.ready;
	assign ld_s3      = !v_s3 || ld_out;
	assign item_ready = ld_s3;

	assign margin_sum = {1'b0, cfg.presence_margin_pct} + (PCT_W + 1)'(PCT_BASE);
	assign diff       = (item.sum >= item.prev) ? item.sum - item.prev : item.prev - item.sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (ld_s3) begin
				v_s3 <= item_valid;
			end
			if (ld_out) begin
				result_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s3 && item_valid) begin
			en_s3         <= item.en;
			stored_s3     <= item.stored;
			latest_s3     <= item.latest;
			obstacle_s3   <= item.latest <= cfg.obstacle_limit;
			sum_zero_s3   <= item.sum == '0;
			limit_nz_s3   <= cfg.presence_limit != '0;
			pres_lhs_s3   <= cmp_t'(cfg.presence_limit) * cmp_t'(PRES_SCALE);
			pres_rhs_s3   <= cmp_t'(margin_sum) * cmp_t'(item.sum);
			diff100_s3    <= cmp_t'(diff) * cmp_t'(PCT_BASE);
			strong_rhs_s3 <= cmp_t'(cfg.strong_change_pct) * cmp_t'(item.prev);
			weak_rhs_s3   <= cmp_t'(cfg.weak_change_pct) * cmp_t'(item.prev);
		end
	end

	// a zero ring sum gives presence from a nonzero limit alone
	assign presence  = sum_zero_s3 ? limit_nz_s3 : (pres_lhs_s3 >= pres_rhs_s3);
	assign is_strong = presence && (diff100_s3 > strong_rhs_s3);
	assign is_weak   = presence && !is_strong && (diff100_s3 < weak_rhs_s3);

	always_comb begin
		flags                = '0;
		flags[FLAG_OBSTACLE] = obstacle_s3;
		flags[FLAG_PRESENCE] = presence;
		flags[FLAG_STRONG]   = is_strong;
		flags[FLAG_WEAK]     = is_weak;
		flags[FLAG_MODERATE] = presence && !is_strong && !is_weak;
	end

	always_ff @(posedge clk) begin
		if (ld_out && v_s3) begin
			reading_stored_q  <= stored_s3;
			breach_flags_q    <= en_s3 ? flags : '0;
			latest_distance_q <= en_s3 ? latest_s3 : '0;
		end
	end

	assign result.valid           = result_valid_q;
	assign result.reading_stored  = reading_stored_q;
	assign result.breach_flags    = breach_flags_q;
	assign result.latest_distance = latest_distance_q;

endmodule

`default_nettype wire

@@ tb/echo_range_presence_detector_tb.sv @@
`default_nettype none

module echo_range_presence_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import erpd_pkg::*;

	localparam int DIST_MAX    = (1 << DIST_W) - 1;
	localparam int HOLD_CYCLES = 120;
	localparam int TAIL_CYCLES = 8;

	typedef struct packed {
		logic [ECHO_W-1:0] duration;
		logic              seen;
	} echo_item_t;

	typedef struct packed {
		logic               stored;
		logic [FLAGS_W-1:0] flags;
		dist_t              latest;
	} range_report_t;

	logic clk = 1'b0;
	logic arst_n;

	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	erpd_in_if  echo_bus ();
	erpd_out_if report_bus ();

	echo_range_presence_detector i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.echo    (echo_bus.sink),
		.result  (report_bus.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #4 clk = ~clk;

	// register mirror and ring state of the detector
	logic            cfg_en;
	dist_t           cfg_obstacle;
	dist_t           cfg_presence;
	pct_t            cfg_margin;
	pct_t            cfg_strong;
	pct_t            cfg_weak;
	dist_t           ring [RING_DEPTH];
	int unsigned     wr_slot;
	longint unsigned ring_sum;
	longint unsigned prev_sum;

	echo_item_t    pending_echoes [$];
	range_report_t expected_reports [$];
	int            mismatch_count = 0;

	bit          src_gaps_on;
	bit          snk_stalls_on;
	int unsigned hold_asked;
	int unsigned hold_taken;
	int unsigned gap_left;
	int unsigned stall_left;
	echo_item_t    next_echo;
	range_report_t want;

	function automatic range_report_t compute_report(input logic [ECHO_W-1:0] duration,
			input logic seen);
		range_report_t   rep;
		dist_t           new_dist;
		dist_t           latest;
		longint unsigned s;
		longint unsigned p;
		longint unsigned diff;
		logic            present;
		rep = '0;
		if (!cfg_en)
			return rep;
		if (seen) begin
			new_dist = dist_t'((32'(duration) * 32'd256) / 32'd148);
			prev_sum = ring_sum;
			ring_sum = ring_sum - ring[wr_slot] + new_dist;
			ring[wr_slot] = new_dist;
			wr_slot = (wr_slot + 1) % RING_DEPTH;
			rep.stored = 1'b1;
		end
		latest = ring[(wr_slot + RING_DEPTH - 1) % RING_DEPTH];
		if (latest <= cfg_obstacle)
			rep.flags[FLAG_OBSTACLE] = 1'b1;
		s = ring_sum;
		p = prev_sum;
		// empty average: any nonzero presence limit counts as above it
		if (s == 0)
			present = (cfg_presence != 0);
		else
			present = (longint'(PRES_SCALE) * cfg_presence) >=
				((longint'(PCT_BASE) + cfg_margin) * s);
		if (present) begin
			rep.flags[FLAG_PRESENCE] = 1'b1;
			diff = (s >= p) ? s - p : p - s;
			if (longint'(PCT_BASE) * diff > cfg_strong * p)
				rep.flags[FLAG_STRONG] = 1'b1;
			else if (longint'(PCT_BASE) * diff < cfg_weak * p)
				rep.flags[FLAG_WEAK] = 1'b1;
			else
				rep.flags[FLAG_MODERATE] = 1'b1;
		end
		rep.latest = latest;
		return rep;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		else
			return $urandom_range(25, 60);
	endfunction

	// mostly readings around a base duration so that averages settle, the rest noise
	function automatic echo_item_t make_echo(input int unsigned base_dur);
		echo_item_t  it;
		int unsigned pick;
		int unsigned spread;
		int unsigned lo;
		int unsigned hi;
		pick = $urandom_range(0, 99);
		spread = base_dur / 12 + 1;
		lo = (base_dur > spread) ? base_dur - spread : 0;
		hi = (base_dur + spread > 65535) ? 65535 : base_dur + spread;
		it.seen = ($urandom_range(0, 4) != 0);
		if (pick < 55)
			it.duration = ECHO_W'($urandom_range(hi, lo));
		else if (pick < 85)
			it.duration = ECHO_W'($urandom_range(0, 65535));
		else if (pick < 92)
			it.duration = '0;
		else
			it.duration = '1;
		return it;
	endfunction

	function automatic void queue_echo(input logic [ECHO_W-1:0] duration, input logic seen);
		echo_item_t it;
		it.duration = duration;
		it.seen = seen;
		pending_echoes.push_back(it);
	endfunction

	task automatic queue_random(input int n, input int unsigned base_dur);
		@(negedge clk);
		repeat (n) pending_echoes.push_back(make_echo(base_dur));
	endtask

	task automatic wait_quiet();
		do
			@(negedge clk);
		while (pending_echoes.size() != 0 || expected_reports.size() != 0 || echo_bus.valid);
	endtask

	task automatic cfg_write(input int unsigned idx, input logic [DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ENABLED:        cfg_en = value[0];
			REG_OBSTACLE_LIMIT: cfg_obstacle = value[DIST_W-1:0];
			REG_PRESENCE_LIMIT: cfg_presence = value[DIST_W-1:0];
			REG_PRESENCE_PCT:   cfg_margin = value[PCT_W-1:0];
			REG_STRONG_PCT:     cfg_strong = value[PCT_W-1:0];
			REG_WEAK_PCT:       cfg_weak = value[PCT_W-1:0];
			default: ;
		endcase
	endtask

	// presence limit near the expected average so the compare goes both ways
	task automatic random_settings(input int unsigned base_dur);
		int unsigned avg_dist;
		int unsigned pres;
		avg_dist = base_dur * 256 / 148;
		pres = avg_dist * $urandom_range(80, 160) / 100;
		if (pres > DIST_MAX)
			pres = DIST_MAX;
		cfg_write(REG_ENABLED, 1);
		cfg_write(REG_OBSTACLE_LIMIT, $urandom_range(0, DIST_MAX));
		cfg_write(REG_PRESENCE_LIMIT, pres);
		cfg_write(REG_PRESENCE_PCT,
			($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40));
		cfg_write(REG_STRONG_PCT, $urandom_range(0, 30));
		cfg_write(REG_WEAK_PCT, $urandom_range(0, 15));
	endtask

	// echo sender: predict on each transfer, hold while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_bus.valid <= 1'b0;
			echo_bus.echo_duration_us <= '0;
			echo_bus.echo_seen <= 1'b0;
			gap_left <= 0;
		end else begin
			if (echo_bus.valid && echo_bus.ready)
				expected_reports.push_back(compute_report(echo_bus.echo_duration_us,
					echo_bus.echo_seen));
			if (!echo_bus.valid || echo_bus.ready) begin
				if (gap_left != 0) begin
					echo_bus.valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_echoes.size() != 0) begin
					next_echo = pending_echoes.pop_front();
					echo_bus.valid <= 1'b1;
					echo_bus.echo_duration_us <= next_echo.duration;
					echo_bus.echo_seen <= next_echo.seen;
					gap_left <= src_gaps_on ? pick_gap() : 0;
				end else begin
					echo_bus.valid <= 1'b0;
				end
			end
		end
	end

	// report receiver: check each transfer, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			report_bus.ready <= 1'b0;
			stall_left <= 0;
			hold_taken <= 0;
		end else begin
			if (report_bus.valid && report_bus.ready) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected report, stored=%0b flags=%05b latest=%0d", $time,
						report_bus.reading_stored, report_bus.breach_flags,
						report_bus.latest_distance);
					mismatch_count++;
				end else begin
					want = expected_reports.pop_front();
					if (report_bus.reading_stored !== want.stored) begin
						$display("%0t: reading_stored expected %0b, got %0b", $time,
							want.stored, report_bus.reading_stored);
						mismatch_count++;
					end
					if (report_bus.breach_flags !== want.flags) begin
						$display("%0t: breach_flags expected %05b, got %05b", $time,
							want.flags, report_bus.breach_flags);
						mismatch_count++;
					end
					if (report_bus.latest_distance !== want.latest) begin
						$display("%0t: latest_distance expected %0d, got %0d", $time,
							want.latest, report_bus.latest_distance);
						mismatch_count++;
					end
				end
			end
			if (hold_taken != hold_asked) begin
				hold_taken <= hold_asked;
				stall_left <= HOLD_CYCLES;
				report_bus.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				report_bus.ready <= 1'b0;
			end else if (snk_stalls_on && $urandom_range(0, 3) == 0) begin
				stall_left <= pick_gap();
				report_bus.ready <= 1'b0;
			end else begin
				report_bus.ready <= 1'b1;
			end
		end
	end

	initial begin
		#5ms;
		$display("echo_range_presence_detector_tb: done, errors");
		$finish;
	end

	initial begin
		int unsigned base_dur;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		echo_bus.valid = 1'b0;
		echo_bus.echo_duration_us = '0;
		echo_bus.echo_seen = 1'b0;
		report_bus.ready = 1'b0;
		src_gaps_on = 1'b1;
		snk_stalls_on = 1'b1;
		hold_asked = 0;
		cfg_en = 1'b1;
		cfg_obstacle = '0;
		cfg_presence = '0;
		cfg_margin = pct_t'(10);
		cfg_strong = pct_t'(10);
		cfg_weak = pct_t'(5);
		foreach (ring[i])
			ring[i] = '0;
		wr_slot = 0;
		ring_sum = 0;
		prev_sum = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// empty ring with a zero presence limit: no presence
		@(negedge clk);
		queue_echo(16'd0, 1'b0);
		wait_quiet();

		// empty ring with a nonzero limit, then zero previous sum, then field extremes
		cfg_write(REG_PRESENCE_LIMIT, 300);
		@(negedge clk);
		queue_echo(16'd0, 1'b0);
		queue_echo(16'd0, 1'b1);
		queue_echo(16'd1000, 1'b1);
		queue_echo(16'd1000, 1'b1);
		queue_echo('1, 1'b1);
		queue_echo(16'd147, 1'b1);
		queue_echo(16'd148, 1'b1);
		wait_quiet();

		// fill the ring with one distance: no change, obstacle right at its limit
		cfg_write(REG_OBSTACLE_LIMIT, 1729);
		cfg_write(REG_PRESENCE_LIMIT, DIST_MAX);
		cfg_write(REG_PRESENCE_PCT, 0);
		@(negedge clk);
		repeat (9) queue_echo(16'd1000, 1'b1);
		wait_quiet();

		// disabled: all zero, ring untouched
		cfg_write(REG_ENABLED, 0);
		@(negedge clk);
		queue_echo('1, 1'b1);
		queue_echo(16'd5, 1'b1);
		queue_echo(16'd0, 1'b0);
		wait_quiet();
		cfg_write(REG_ENABLED, 1);
		@(negedge clk);
		queue_echo(16'd0, 1'b0);
		wait_quiet();

		base_dur = $urandom_range(200, 65535);
		random_settings(base_dur);
		queue_random(120, base_dur);
		wait_quiet();

		// a stretch with no idling on either side
		@(negedge clk);
		src_gaps_on = 1'b0;
		snk_stalls_on = 1'b0;
		base_dur = $urandom_range(200, 20000);
		random_settings(base_dur);
		queue_random(80, base_dur);
		wait_quiet();

		// long receiver hold while echoes keep coming: the block must back up
		base_dur = $urandom_range(200, 65535);
		random_settings(base_dur);
		@(negedge clk);
		hold_asked = hold_asked + 1;
		queue_random(60, base_dur);
		wait_quiet();

		@(negedge clk);
		src_gaps_on = 1'b1;
		snk_stalls_on = 1'b1;
		// top values, written with every data bit set
		cfg_write(REG_ENABLED, '1);
		cfg_write(REG_OBSTACLE_LIMIT, '1);
		cfg_write(REG_PRESENCE_LIMIT, '1);
		cfg_write(REG_PRESENCE_PCT, '1);
		cfg_write(REG_STRONG_PCT, '1);
		cfg_write(REG_WEAK_PCT, '1);
		queue_random(60, $urandom_range(200, 65535));
		wait_quiet();

		cfg_write(REG_OBSTACLE_LIMIT, 0);
		cfg_write(REG_PRESENCE_LIMIT, 0);
		cfg_write(REG_PRESENCE_PCT, 0);
		cfg_write(REG_STRONG_PCT, 0);
		cfg_write(REG_WEAK_PCT, 0);
		queue_random(60, $urandom_range(200, 65535));
		wait_quiet();

		// a write past the last register must change nothing
		cfg_write(NUM_REGS + 1, '1);
		cfg_write(REG_ENABLED, 0);
		queue_random(40, $urandom_range(200, 65535));
		wait_quiet();

		// weak limit above strong limit: strong wins
		base_dur = $urandom_range(200, 65535);
		random_settings(base_dur);
		cfg_write(REG_STRONG_PCT, $urandom_range(0, 10));
		cfg_write(REG_WEAK_PCT, $urandom_range(20, 255));
		queue_random(130, base_dur);
		wait_quiet();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("echo_range_presence_detector_tb: done, clean");
		else
			$display("echo_range_presence_detector_tb: done, errors");
		$finish;
	end

endmodule

`default_nettype wire

@@ echo_range_presence_detector.f @@
src/erpd_pkg.sv
src/erpd_in_if.sv
src/erpd_out_if.sv
src/erpd_ram.sv
src/erpd_ring.sv
src/erpd_eval.sv
src/echo_range_presence_detector.sv
tb/echo_range_presence_detector_tb.sv
